// ===== rtl/lrotf_pkg.sv =====
// Shared constants, types and the arctangent table for the lidar offset-time filter.
// No dependencies; every other file but lrotf_ram imports this package.
package lrotf_pkg;

	localparam int RINGS        = 64;
	localparam int CORDIC_STEPS = 16;
	localparam int RING_AW      = (RINGS > 1) ? $clog2(RINGS) : 1;
	localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

	localparam int XY_W  = 24;            // coordinate width
	localparam int CW    = XY_W + 19;     // CORDIC x/y datapath (Q16 plus growth)
	localparam int ZW    = 26;            // CORDIC angle, degrees Q16
	localparam int AZ_W  = 16;            // azimuth, degrees Q9.7
	localparam int OFS_W = 32;            // offset time in us
	localparam int RAM_W = AZ_W + OFS_W;  // first azimuth and last offset per ring

	localparam logic signed [ZW-1:0] BASE_Q16 = 26'sd11796480;  // 180 deg in Q16
	localparam int AZ_HALF = 23040;
	localparam int AZ_FULL = 46080;

	// us = round(lag * 100000 / 46208) = floor((lag * 3125 + 722) / 1444)
	// floor(n / 1444) = (floor(n / 4) * 23794833) >> 33, exact for n < 2^28
	localparam int LAG_W      = 17;
	localparam int N_W        = 28;
	localparam int Q_W        = 17;
	localparam int TIME_MUL   = 3125;
	localparam int TIME_RND   = 722;
	localparam int TIME_RECIP = 23794833;
	localparam int RECIP_W    = 25;
	localparam int RECIP_SH   = 33;
	localparam int PROD_W     = N_W - 2 + RECIP_W;
	localparam int REV_US     = 99723;

	localparam int SQ_W = 2 * XY_W;
	localparam int R2_W = SQ_W + 2;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_BLIND = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECIM = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CORDIC, ST_LAG, ST_MUL, ST_DIV, ST_SQ, ST_CMP, ST_OUT
	} state_t;

	// atan(2^-i) in degrees Q16
	function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
		logic signed [ZW-1:0] v;
		case (i)
			5'd0:  v = 26'sd2949120;
			5'd1:  v = 26'sd1740967;
			5'd2:  v = 26'sd919879;
			5'd3:  v = 26'sd466945;
			5'd4:  v = 26'sd234379;
			5'd5:  v = 26'sd117304;
			5'd6:  v = 26'sd58666;
			5'd7:  v = 26'sd29335;
			5'd8:  v = 26'sd14668;
			5'd9:  v = 26'sd7334;
			5'd10: v = 26'sd3667;
			5'd11: v = 26'sd1833;
			5'd12: v = 26'sd917;
			5'd13: v = 26'sd458;
			5'd14: v = 26'sd229;
			5'd15: v = 26'sd115;
			5'd16: v = 26'sd57;
			5'd17: v = 26'sd29;
			5'd18: v = 26'sd14;
			5'd19: v = 26'sd7;
			5'd20: v = 26'sd4;
			5'd21: v = 26'sd2;
			5'd22: v = 26'sd1;
			default: v = 26'sd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/lrotf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lrotf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/lrotf_cordic.sv =====
// Iterative vectoring CORDIC: atan2(y, x) in degrees Q9.7, one rotation per cycle.
// Depends on lrotf_pkg.
module lrotf_cordic import lrotf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [XY_W-1:0] x_in,
	input  logic signed [XY_W-1:0] y_in,
	output logic                   done,
	output logic signed [AZ_W-1:0] az
);

	logic signed [CW-1:0] x_q, y_q, dx, dy, xs, ys;
	logic signed [ZW-1:0] z_q, base_q;
	logic [STEP_W-1:0]    step_q;
	logic                 run_q, done_q, zero_q;
	logic signed [ZW:0]   zf;
	logic signed [ZW-9:0] zs;

	assign xs = {{(CW-XY_W-16){x_in[XY_W-1]}}, x_in, 16'd0};
	assign ys = {{(CW-XY_W-16){y_in[XY_W-1]}}, y_in, 16'd0};
	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (x_in == '0) && (y_in == '0);
			z_q    <= '0;
			if (x_in < 0) begin
				x_q    <= -xs;
				y_q    <= -ys;
				base_q <= (y_in >= 0) ? BASE_Q16 : -BASE_Q16;
			end else begin
				x_q    <= xs;
				y_q    <= ys;
				base_q <= '0;
			end
		end else if (run_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_q16(5'(step_q));
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_q16(5'(step_q));
			end
		end
	end

	// round to Q9.7 and wrap into (-180, 180]
	always_comb begin
		zf = (ZW+1)'(z_q) + (ZW+1)'(base_q) + (ZW+1)'(256);
		zs = (ZW-8)'(zf >>> 9);
		if (zs > (ZW-8)'(AZ_HALF)) begin
			zs = zs - (ZW-8)'(AZ_FULL);
		end
		if (zs <= -(ZW-8)'(AZ_HALF)) begin
			zs = zs + (ZW-8)'(AZ_FULL);
		end
		az = zero_q ? '0 : AZ_W'(zs);
	end

	assign done = done_q;

endmodule

// ===== rtl/lrotf_tdiv.sv =====
// Lag-to-time conversion: scale and round, then divide by 1444 through a reciprocal multiply.
// Takes lag in Q9.7 degrees; registers the scaled numerator, then the rounded time in us.
// Depends on lrotf_pkg.
module lrotf_tdiv import lrotf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [LAG_W-1:0] lag,
	output logic             done,
	output logic [Q_W-1:0]   quot
);

	logic [N_W-1:0]    num, num_q;
	logic [PROD_W-1:0] prod;
	logic [Q_W-1:0]    q_q;
	logic              run_q, done_q;

	assign num  = N_W'(lag * N_W'(TIME_MUL)) + N_W'(TIME_RND);
	// drop the factor 4 by a shift, then divide by 361 with the reciprocal
	assign prod = PROD_W'(num_q[N_W-1:2]) * PROD_W'(TIME_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			run_q  <= start;
			done_q <= run_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
		end
		if (run_q) begin
			q_q <= prod[RECIP_SH+Q_W-1:RECIP_SH];
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

// ===== rtl/lidar_ring_offset_time_filter.sv =====
// Top level of the lidar offset-time and decimation filter.
// Depends on lrotf_pkg, lrotf_ram, lrotf_cordic and lrotf_tdiv.

// One point is taken per request and the block is busy until it is done.
// A point with sensor times goes from its request through the squares,
// taken in turn through one multiplier, to the range compare and the
// output load; it is dropped at the compare when it fails. A point
// without times first runs the CORDIC (load plus 16 rotations), then the
// lag, the start of the conversion and the reciprocal multiply, then the
// same squares, compare and load. The first point of a ring finishes
// after the CORDIC. A stalled receiver adds its stall to the output load.
// Per-ring first azimuth and last offset sit in a RINGS-deep RAM; the
// first-seen marks are flip-flops cleared at reset and on frame_start.
// A finished point waits in the output register, so the next request can
// be taken while it is unclaimed.
// Configuration writes are always accepted; write them only while the
// block is idle.
module lidar_ring_offset_time_filter import lrotf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [127:0]         s_tdata,   // pos_x, pos_y, pos_z, intensity, ring, point_time
	input  logic [1:0]           s_tuser,   // frame_start, frame_has_times
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [119:0]         m_tdata,   // out_x, out_y, out_z, out_intensity, out_time
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	// input request fields
	logic signed [XY_W-1:0] in_x, in_y, in_z;
	logic [15:0]            in_int;
	logic [5:0]             in_ring;
	logic [OFS_W-1:0]       in_time;
	logic                   in_fs, in_ht, s_acc, in_range;
	logic [RING_AW+5:0]     ring_ext;

	assign in_x    = s_tdata[23:0];
	assign in_y    = s_tdata[47:24];
	assign in_z    = s_tdata[71:48];
	assign in_int  = s_tdata[87:72];
	assign in_ring = s_tdata[93:88];
	assign in_time = s_tdata[125:94];
	assign in_fs   = s_tuser[0];
	assign in_ht   = s_tuser[1];

	assign ring_ext = {{RING_AW{1'b0}}, in_ring};
	assign in_range = ({26'd0, in_ring} < 32'(RINGS));

	state_t state_q, state_d;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// config registers
	logic [15:0] blind_q, decim_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blind_q <= 16'd10;
			decim_q <= 16'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BLIND: blind_q <= cfg_data;
				REG_DECIM: decim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item registers
	logic signed [XY_W-1:0] x_q, y_q, z_q;
	logic [15:0]            int_q;
	logic [RING_AW-1:0]     ring_q;
	logic [OFS_W-1:0]       t_q;
	logic                   elig_q;
	logic signed [AZ_W-1:0] az_q;
	logic [LAG_W-1:0]       lag_q;

	// frame index phase
	logic [15:0] phase_q, ph, dec;
	assign ph  = in_fs ? 16'd0 : phase_q;
	assign dec = (decim_q == 16'd0) ? 16'd1 : decim_q;

	// ring state
	logic [RINGS-1:0] seen_q;
	logic             ram_we;
	logic [RAM_W-1:0] ram_wdata, ram_rdata;

	lrotf_ram #(.WIDTH(RAM_W), .DEPTH(RINGS)) u_ring_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ring_q),
		.wdata(ram_wdata),
		.re   (s_acc),
		.raddr(ring_ext[RING_AW-1:0]),
		.rdata(ram_rdata)
	);

	// azimuth and time conversion units
	logic                   cor_start, cor_done, div_start, div_done;
	logic signed [AZ_W-1:0] cor_az;
	logic [Q_W-1:0]         div_q;

	assign cor_start = s_acc && in_range && !in_ht;
	assign div_start = (state_q == ST_MUL);

	lrotf_cordic u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cor_start),
		.x_in  (in_x),
		.y_in  (in_y),
		.done  (cor_done),
		.az    (cor_az)
	);

	lrotf_tdiv u_tdiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.lag   (lag_q),
		.done  (div_done),
		.quot  (div_q)
	);

	// lag behind the ring's first azimuth, one revolution added on wrap
	logic signed [AZ_W-1:0]  fa;
	logic signed [AZ_W+1:0]  lag;
	logic [OFS_W-1:0]        last_ofs, us, t_new;

	assign fa       = ram_rdata[RAM_W-1:OFS_W];
	assign last_ofs = ram_rdata[OFS_W-1:0];

	always_comb begin
		lag = (AZ_W+2)'(fa) - (AZ_W+2)'(az_q);
		if (az_q > fa) begin
			lag = lag + (AZ_W+2)'(AZ_FULL);
		end
		if (lag < 0) begin
			lag = '0;
		end
	end

	assign us    = OFS_W'(div_q);
	assign t_new = (us < last_ofs) ? us + OFS_W'(REV_US) : us;

	// squared range through one multiplier
	logic [1:0]             sq_cnt_q;
	logic signed [XY_W-1:0] sq_op;
	logic signed [SQ_W-1:0] sq;
	logic [SQ_W-1:0]        prod_q;
	logic [R2_W-1:0]        acc_q;
	logic [31:0]            b2_q;

	always_comb begin
		case (sq_cnt_q)
			2'd0:    sq_op = x_q;
			2'd1:    sq_op = y_q;
			default: sq_op = z_q;
		endcase
		sq = sq_op * sq_op;
	end

	// output register
	logic         m_valid_q;
	logic [119:0] m_data_q;
	logic         out_load;

	assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_tready);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// sequencer
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_wdata = {az_q, t_new};
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					if (!in_range) begin
						state_d = ST_IDLE;
					end else if (in_ht) begin
						state_d = ST_SQ;
					end else begin
						state_d = ST_CORDIC;
					end
				end
			end
			ST_CORDIC: begin
				if (cor_done) begin
					if (!seen_q[ring_q]) begin
						ram_we    = 1'b1;
						ram_wdata = {cor_az, {OFS_W{1'b0}}};
						state_d   = ST_IDLE;
					end else begin
						state_d = ST_LAG;
					end
				end
			end
			ST_LAG: state_d = ST_MUL;
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					ram_we    = 1'b1;
					ram_wdata = {fa, t_new};
					state_d   = ST_SQ;
				end
			end
			ST_SQ: begin
				if (sq_cnt_q == 2'd3) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (elig_q && (acc_q > R2_W'(b2_q)) && (z_q != '0)) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= '0;
			seen_q    <= '0;
			m_valid_q <= 1'b0;
			sq_cnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (s_acc) begin
				phase_q <= ({1'b0, ph} + 17'd1 >= {1'b0, dec}) ? 16'd0 : ph + 16'd1;
				if (in_fs) begin
					seen_q <= '0;
				end
			end
			if (state_q == ST_CORDIC && cor_done) begin
				seen_q[ring_q] <= 1'b1;
			end
			if (state_q == ST_SQ) begin
				sq_cnt_q <= sq_cnt_q + 2'd1;
			end else begin
				sq_cnt_q <= '0;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			x_q    <= in_x;
			y_q    <= in_y;
			z_q    <= in_z;
			int_q  <= in_int;
			ring_q <= ring_ext[RING_AW-1:0];
			t_q    <= in_time;
			elig_q <= (ph == 16'd0);
		end
		if (state_q == ST_CORDIC && cor_done) begin
			az_q <= cor_az;
		end
		if (state_q == ST_LAG) begin
			lag_q <= LAG_W'(lag);
		end
		if (state_q == ST_DIV && div_done) begin
			t_q <= t_new;
		end
		if (state_q != ST_SQ) begin
			acc_q <= '0;
			b2_q  <= blind_q * blind_q;
		end else begin
			prod_q <= SQ_W'(sq);
			if (sq_cnt_q != 2'd0) begin
				acc_q <= acc_q + R2_W'(prod_q);
			end
		end
		if (out_load) begin
			m_data_q <= {t_q, int_q, z_q, y_q, x_q};
		end
	end

endmodule

// ===== rtl/lrotf_checker.sv =====
// Port-level assertions for the lidar offset-time filter, bound to the top level.
// Depends on lrotf_pkg.
module lrotf_checker import lrotf_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [119:0] m_tdata,
	input logic         cfg_ready
);

	// a held result keeps its request
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output request dropped or changed while stalled");

	// one point at a time: busy right after a request is taken (an out-of-range ring stays idle)
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on consecutive cycles");

	// kept points never have zero height
	a_z_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[71:48] != 24'd0))
		else $error("point with zero z passed the filter");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config channel stalled");

endmodule

bind lidar_ring_offset_time_filter lrotf_checker u_lrotf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.cfg_ready(cfg_ready)
);
